/* sv/at_rsp_pkg.sv */
`default_nettype none

package at_rsp_pkg;

   // Characters of the response grammar.
   localparam logic [7:0] CH_CR        = 8'h0d;
   localparam logic [7:0] CH_LF        = 8'h0a;
   localparam logic [7:0] CH_PRINT_LO  = 8'h1f;
   localparam logic [7:0] CH_PRINT_HI  = 8'h7f;
   localparam logic [7:0] CH_PLUS      = 8'h2b;
   localparam logic [7:0] CH_O         = 8'h4f;
   localparam logic [7:0] CH_K         = 8'h4b;
   localparam logic [7:0] CH_E         = 8'h45;
   localparam logic [7:0] CH_R         = 8'h52;

   // Lengths of the two recognised prefixes of line 0.
   localparam int COPN_LEN = 6;
   localparam int CSQ_LEN  = 5;

   // Widest line and column indexes that the store write port carries.
   localparam int WR_LINE_W = 6;
   localparam int WR_COL_W  = 10;

   // parse_status codes.
   localparam logic [1:0] STAT_BUSY  = 2'd0;
   localparam logic [1:0] STAT_OK    = 2'd1;
   localparam logic [1:0] STAT_ERROR = 2'd2;

   // command_kind codes.
   localparam logic [1:0] KIND_ERROR   = 2'd0;
   localparam logic [1:0] KIND_COPN    = 2'd1;
   localparam logic [1:0] KIND_CSQ     = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   typedef enum logic [4:0] {
      ST_CR0        = 5'd0,
      ST_LF0        = 5'd1,
      ST_FIRST      = 5'd2,
      ST_OK_K       = 5'd3,
      ST_OK_CR      = 5'd4,
      ST_OK_LF      = 5'd5,
      ST_E_R1       = 5'd6,
      ST_E_R2       = 5'd7,
      ST_E_O        = 5'd8,
      ST_E_R3       = 5'd9,
      ST_E_CR       = 5'd10,
      ST_E_LF       = 5'd11,
      ST_INFO_START = 5'd12,
      ST_INFO_BODY  = 5'd13,
      ST_INFO_LF    = 5'd14,
      ST_LINE_END   = 5'd15,
      ST_BLANK_LF   = 5'd16,
      ST_FINAL      = 5'd17
   } gstate_type;

   typedef struct packed {
      logic [1:0] parse_status;
      logic       response_is_ok;
      logic [1:0] command_kind;
      logic [3:0] lines_captured;
      logic       byte_stored;
      logic [2:0] store_line;
      logic [5:0] store_column;
   } rsp_type;

   typedef struct packed {
      logic                 en;
      logic [WR_LINE_W-1:0] line;
      logic [WR_COL_W-1:0]  column;
      logic [7:0]           data;
   } store_wr_type;

   function automatic logic [7:0] copn_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h2b; // '+'
         3'd1:    c = 8'h43; // 'C'
         3'd2:    c = 8'h4f; // 'O'
         3'd3:    c = 8'h50; // 'P'
         3'd4:    c = 8'h4e; // 'N'
         3'd5:    c = 8'h3a; // ':'
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] csq_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h2b; // '+'
         3'd1:    c = 8'h43; // 'C'
         3'd2:    c = 8'h53; // 'S'
         3'd3:    c = 8'h51; // 'Q'
         3'd4:    c = 8'h3a; // ':'
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* sv/at_req_if.sv */
`default_nettype none

interface at_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* sv/at_rsp_if.sv */
`default_nettype none

interface at_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] parse_status;
   logic       response_is_ok;
   logic [1:0] command_kind;
   logic [3:0] lines_captured;
   logic       byte_stored;
   logic [2:0] store_line;
   logic [5:0] store_column;

   modport source (
      output valid, output parse_status, output response_is_ok, output command_kind,
      output lines_captured, output byte_stored, output store_line, output store_column,
      input ready
   );
   modport sink (
      input valid, input parse_status, input response_is_ok, input command_kind,
      input lines_captured, input byte_stored, input store_line, input store_column,
      output ready
   );
endinterface

`default_nettype wire

/* sv/at_rsp_store.sv */
`default_nettype none

// Line store: one byte written per transaction at line * LINE_BYTES + column.
module at_rsp_store #(
   parameter int MAX_LINES  = 8,
   parameter int LINE_BYTES = 64
) (
   input  wire                         clock,
   input  wire at_rsp_pkg::store_wr_type wr
);

   localparam int DEPTH = MAX_LINES * LINE_BYTES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] wr_addr;

   assign wr_addr = AW'(int'(wr.line) * LINE_BYTES + int'(wr.column));

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

endmodule

`default_nettype wire

/* sv/at_rsp_fsm.sv */
`default_nettype none

// Grammar sequencer with line and column counters and prefix matching.
module at_rsp_fsm #(
   parameter int MAX_LINES  = 8,
   parameter int LINE_BYTES = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         accept,
   input  wire [7:0]                   rx_byte,
   output at_rsp_pkg::rsp_type         rsp,
   output at_rsp_pkg::store_wr_type    wr
);

   localparam int LW = $clog2(MAX_LINES + 1);
   localparam int CW = $clog2(LINE_BYTES + 1);

   at_rsp_pkg::gstate_type state_ff, state_in;
   logic [LW-1:0] line_ff, line_in, line_upd;
   logic [CW-1:0] col_ff, col_in, col_upd;
   logic [1:0]    flags_ff, flags_in, flags_upd;

   logic err, done, done_ok, put, end_line, stored, printable;
   logic [1:0] kind;

   logic [LW+3:0] lines_ext;
   logic [LW+2:0] sline_ext;
   logic [LW+5:0] wline_ext;
   logic [CW+5:0] scol_ext;
   logic [CW+9:0] wcol_ext;

   assign printable = (rx_byte > at_rsp_pkg::CH_PRINT_LO) && (rx_byte < at_rsp_pkg::CH_PRINT_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= at_rsp_pkg::ST_CR0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= '0;
         col_ff   <= '0;
         flags_ff <= 2'b11;
      end else if (accept) begin
         line_ff  <= line_in;
         col_ff   <= col_in;
         flags_ff <= flags_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      err      = 1'b0;
      done     = 1'b0;
      done_ok  = 1'b0;
      put      = 1'b0;
      end_line = 1'b0;

      unique case (state_ff)
         at_rsp_pkg::ST_CR0: begin
            if (rx_byte == at_rsp_pkg::CH_CR) state_in = at_rsp_pkg::ST_LF0;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_LF0: begin
            if (rx_byte == at_rsp_pkg::CH_LF) state_in = at_rsp_pkg::ST_FIRST;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_FIRST, at_rsp_pkg::ST_FINAL: begin
            if (rx_byte == at_rsp_pkg::CH_O) begin
               state_in = at_rsp_pkg::ST_OK_K;
            end else if (rx_byte == at_rsp_pkg::CH_E) begin
               state_in = at_rsp_pkg::ST_E_R1;
            end else if (state_ff == at_rsp_pkg::ST_FIRST && rx_byte == at_rsp_pkg::CH_PLUS) begin
               state_in = at_rsp_pkg::ST_INFO_START;
               put      = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         at_rsp_pkg::ST_OK_K: begin
            if (rx_byte == at_rsp_pkg::CH_K) state_in = at_rsp_pkg::ST_OK_CR;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_OK_CR: begin
            if (rx_byte == at_rsp_pkg::CH_CR) state_in = at_rsp_pkg::ST_OK_LF;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_OK_LF: begin
            if (rx_byte == at_rsp_pkg::CH_LF) begin
               done    = 1'b1;
               done_ok = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         at_rsp_pkg::ST_E_R1: begin
            if (rx_byte == at_rsp_pkg::CH_R) state_in = at_rsp_pkg::ST_E_R2;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_E_R2: begin
            if (rx_byte == at_rsp_pkg::CH_R) state_in = at_rsp_pkg::ST_E_O;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_E_O: begin
            if (rx_byte == at_rsp_pkg::CH_O) state_in = at_rsp_pkg::ST_E_R3;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_E_R3: begin
            if (rx_byte == at_rsp_pkg::CH_R) state_in = at_rsp_pkg::ST_E_CR;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_E_CR: begin
            if (rx_byte == at_rsp_pkg::CH_CR) state_in = at_rsp_pkg::ST_E_LF;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_E_LF: begin
            if (rx_byte == at_rsp_pkg::CH_LF) done = 1'b1;
            else err = 1'b1;
         end
         at_rsp_pkg::ST_INFO_START: begin
            if (printable && rx_byte != at_rsp_pkg::CH_PLUS) begin
               state_in = at_rsp_pkg::ST_INFO_BODY;
               put      = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         at_rsp_pkg::ST_INFO_BODY: begin
            if (printable) begin
               put = 1'b1;
            end else if (rx_byte == at_rsp_pkg::CH_CR) begin
               state_in = at_rsp_pkg::ST_INFO_LF;
               put      = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         at_rsp_pkg::ST_INFO_LF: begin
            if (rx_byte == at_rsp_pkg::CH_LF) begin
               state_in = at_rsp_pkg::ST_LINE_END;
               put      = 1'b1;
               end_line = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         at_rsp_pkg::ST_LINE_END: begin
            if (rx_byte == at_rsp_pkg::CH_CR) begin
               state_in = at_rsp_pkg::ST_BLANK_LF;
            end else if (rx_byte == at_rsp_pkg::CH_PLUS) begin
               state_in = at_rsp_pkg::ST_INFO_START;
               put      = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         at_rsp_pkg::ST_BLANK_LF: begin
            if (rx_byte == at_rsp_pkg::CH_LF) state_in = at_rsp_pkg::ST_FINAL;
            else err = 1'b1;
         end
         default: err = 1'b1;
      endcase

      // Store write and counter update for a line byte.
      line_upd  = line_ff;
      col_upd   = col_ff;
      flags_upd = flags_ff;
      stored    = 1'b0;
      if (put && line_ff < LW'(MAX_LINES)) begin
         if (col_ff < CW'(LINE_BYTES)) begin
            stored = 1'b1;
            if (line_ff == '0) begin
               if (col_ff < CW'(at_rsp_pkg::COPN_LEN) &&
                   rx_byte != at_rsp_pkg::copn_char(col_ff[2:0])) begin
                  flags_upd[0] = 1'b0;
               end
               if (col_ff < CW'(at_rsp_pkg::CSQ_LEN) &&
                   rx_byte != at_rsp_pkg::csq_char(col_ff[2:0])) begin
                  flags_upd[1] = 1'b0;
               end
            end
            col_upd = col_ff + CW'(1);
         end
         if (end_line) begin
            line_upd = line_ff + LW'(1);
            col_upd  = '0;
         end
      end

      if (!done_ok) begin
         kind = at_rsp_pkg::KIND_ERROR;
      end else if (line_upd != '0 && flags_upd[0]) begin
         kind = at_rsp_pkg::KIND_COPN;
      end else if (line_upd != '0 && flags_upd[1]) begin
         kind = at_rsp_pkg::KIND_CSQ;
      end else begin
         kind = at_rsp_pkg::KIND_UNKNOWN;
      end

      // Any ready result sends the grammar back to its start.
      if (err || done) begin
         state_in = at_rsp_pkg::ST_CR0;
         line_in  = '0;
         col_in   = '0;
         flags_in = 2'b11;
      end else begin
         line_in  = line_upd;
         col_in   = col_upd;
         flags_in = flags_upd;
      end
   end

   assign lines_ext = {4'b0000, line_upd};
   assign sline_ext = {3'b000, line_ff};
   assign wline_ext = {6'b000000, line_ff};
   assign scol_ext  = {6'b000000, col_ff};
   assign wcol_ext  = {10'b0000000000, col_ff};

   always_comb begin
      if (err) begin
         rsp.parse_status = at_rsp_pkg::STAT_ERROR;
      end else if (done) begin
         rsp.parse_status = at_rsp_pkg::STAT_OK;
      end else begin
         rsp.parse_status = at_rsp_pkg::STAT_BUSY;
      end
      rsp.response_is_ok = done && !err && done_ok;
      rsp.command_kind   = (done && !err) ? kind : at_rsp_pkg::KIND_ERROR;
      rsp.lines_captured = lines_ext[3:0];
      rsp.byte_stored    = stored;
      rsp.store_line     = stored ? sline_ext[2:0] : 3'd0;
      rsp.store_column   = stored ? scol_ext[5:0] : 6'd0;

      wr.en     = stored && accept;
      wr.line   = wline_ext[at_rsp_pkg::WR_LINE_W-1:0];
      wr.column = wcol_ext[at_rsp_pkg::WR_COL_W-1:0];
      wr.data   = rx_byte;
   end

endmodule

`default_nettype wire

/* sv/at_rsp_buf.sv */
`default_nettype none

// Two-entry output buffer: a result register and a skid register behind it.
module at_rsp_buf (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  wire at_rsp_pkg::rsp_type in_data,
   output logic                   out_valid,
   input  wire                    out_ready,
   output at_rsp_pkg::rsp_type    out_data
);

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   at_rsp_pkg::rsp_type out_data_ff, out_data_in;
   at_rsp_pkg::rsp_type skid_data_ff, skid_data_in;
   logic                push, pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

/* sv/at_response_parser.sv */
// A byte's result is registered in the output buffer. Throughput: one byte per cycle while
// the output buffer has room; the grammar step and the store write complete in the cycle that
// takes the byte. A two-entry output buffer lets the parser keep taking bytes while one result
// waits. Reset is synchronous and active high: it returns the grammar to the first CR, clears
// the line and column counts and output buffer and sets the prefix flags; the line store is not cleared.
`default_nettype none

module at_response_parser #(
   parameter int MAX_LINES  = 8,
   parameter int LINE_BYTES = 64
) (
   input  wire          clock,
   input  wire          reset,
   at_req_if.sink       req_ch,
   at_rsp_if.source     rsp_ch
);

   // A byte is taken whenever the output buffer has room for its result; every byte
   // yields exactly one result, so buffer room is the only back-pressure.
   logic                       buf_ready;
   logic                       accept;
   at_rsp_pkg::rsp_type        fsm_rsp;
   at_rsp_pkg::rsp_type        out_rsp;
   at_rsp_pkg::store_wr_type   store_wr;

   assign req_ch.ready = buf_ready;
   assign accept       = req_ch.valid && buf_ready;

   // The sequencer follows the response grammar, counts lines and columns and
   // matches the prefix of line 0 to find the command kind.
   at_rsp_fsm #(
      .MAX_LINES  (MAX_LINES),
      .LINE_BYTES (LINE_BYTES)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_ch.rx_byte),
      .rsp     (fsm_rsp),
      .wr      (store_wr)
   );

   // Bytes of information lines, with their CR and LF, land in the line store.
   at_rsp_store #(
      .MAX_LINES  (MAX_LINES),
      .LINE_BYTES (LINE_BYTES)
   ) u_store (
      .clock (clock),
      .wr    (store_wr)
   );

   // The result register and its skid register part the two handshakes.
   at_rsp_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (buf_ready),
      .in_data   (fsm_rsp),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_rsp)
   );

   assign rsp_ch.parse_status   = out_rsp.parse_status;
   assign rsp_ch.response_is_ok = out_rsp.response_is_ok;
   assign rsp_ch.command_kind   = out_rsp.command_kind;
   assign rsp_ch.lines_captured = out_rsp.lines_captured;
   assign rsp_ch.byte_stored    = out_rsp.byte_stored;
   assign rsp_ch.store_line     = out_rsp.store_line;
   assign rsp_ch.store_column   = out_rsp.store_column;

endmodule

`default_nettype wire

/* sv/at_rsp_checker.sv */
`default_nettype none

module at_rsp_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [1:0] parse_status,
   input wire       response_is_ok,
   input wire [1:0] command_kind,
   input wire       byte_stored,
   input wire [2:0] store_line,
   input wire [5:0] store_column
);

   // No result may survive a reset.
   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(parse_status) &&
      $stable(command_kind) && $stable(store_column))
      else $error("stalled result changed");

   // Only three status codes exist, and a busy or error result carries no verdict.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && parse_status != at_rsp_pkg::STAT_OK |->
      parse_status != 2'd3 && !response_is_ok && command_kind == at_rsp_pkg::KIND_ERROR)
      else $error("bad status or verdict on non-ready result");

   // A final ERROR is reported as an error response kind.
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && parse_status == at_rsp_pkg::STAT_OK && !response_is_ok |->
      command_kind == at_rsp_pkg::KIND_ERROR)
      else $error("final ERROR with a command kind");

   // An unstored byte reports no position, and a ready result never stores a byte.
   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!byte_stored || parse_status != at_rsp_pkg::STAT_BUSY) |->
      !byte_stored && store_line == 3'd0 && store_column == 6'd0)
      else $error("position reported for an unstored byte");

endmodule

bind at_response_parser at_rsp_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .parse_status   (rsp_ch.parse_status),
   .response_is_ok (rsp_ch.response_is_ok),
   .command_kind   (rsp_ch.command_kind),
   .byte_stored    (rsp_ch.byte_stored),
   .store_line     (rsp_ch.store_line),
   .store_column   (rsp_ch.store_column)
);

`default_nettype wire
